>>> design/matrix_chain_order_parenthesizer_assert.svh
// assertion macros used by the checker
`ifndef MATRIX_CHAIN_ORDER_PARENTHESIZER_ASSERT_SVH
`define MATRIX_CHAIN_ORDER_PARENTHESIZER_ASSERT_SVH

// checked outside reset only
`define MCOP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, also during reset
`define MCOP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/mcop_pkg.sv
package mcop_pkg;

  localparam int MAX_DIMS    = 17;
  localparam int DIM_BITS    = 8;
  localparam int COST_W      = 28;
  localparam int IDX_W       = $clog2(MAX_DIMS);
  localparam int CNT_W       = $clog2(MAX_DIMS + 1);
  localparam int TAB_DEPTH   = MAX_DIMS * MAX_DIMS;
  localparam int TADDR_W     = $clog2(TAB_DEPTH);
  localparam int STACK_DEPTH = 2 * MAX_DIMS;
  localparam int SADDR_W     = $clog2(STACK_DEPTH);
  localparam int SP_W        = $clog2(STACK_DEPTH + 1);
  localparam int ENTRY_W     = 2 * IDX_W;
  localparam int PROD_W      = 3 * DIM_BITS;
  localparam int ACC_W       = ((PROD_W > COST_W) ? PROD_W : COST_W) + 2;
  localparam int SYM_W       = 7;
  localparam int LET_W       = 5;

  localparam logic [COST_W-1:0] COST_TOP = '1;

  localparam logic [SYM_W-1:0] CH_A     = 7'h41;
  localparam logic [SYM_W-1:0] CH_OPEN  = 7'h28;
  localparam logic [SYM_W-1:0] CH_CLOSE = 7'h29;
  localparam logic [SYM_W-1:0] CH_NONE  = 7'h00;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_SHORT = 2'd1,
    ST_DROP  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ALU_MUL = 2'b01,
    ALU_SUM = 2'b10
  } alu_op_t;

  typedef struct packed {
    logic             go;
    alu_op_t          op;
    logic [ACC_W-1:0] a;
    logic [ACC_W-1:0] b;
    logic [ACC_W-1:0] c;
  } alu_req_t;

  typedef struct packed {
    logic                we;
    logic [IDX_W-1:0]    addr;
    logic [DIM_BITS-1:0] data;
  } dim_wr_t;

  typedef struct packed {
    logic             go;
    logic [CNT_W-1:0] n;
    status_t          st;
  } start_t;

  function automatic logic [TADDR_W-1:0] tab_addr(logic [IDX_W-1:0] r, logic [IDX_W-1:0] c);
    return TADDR_W'(32'(r) * MAX_DIMS + 32'(c));
  endfunction

endpackage

>>> design/mcop_alu.sv
module mcop_alu import mcop_pkg::*; (
  input  logic             clk,
  input  alu_req_t         req,
  output logic [ACC_W-1:0] res
);

  logic [ACC_W-1:0] sum;

  assign sum = req.a + req.b + req.c;

  always_ff @(posedge clk) begin
    if (req.go) begin
      case (req.op)
        ALU_MUL: res <= ACC_W'(req.a[2*DIM_BITS-1:0]) * ACC_W'(req.b[DIM_BITS-1:0]);
        ALU_SUM: res <= (sum > ACC_W'(COST_TOP)) ? ACC_W'(COST_TOP) : sum;
        default: res <= res;
      endcase
    end
  end

endmodule

>>> design/mcop_seq.sv
module mcop_seq import mcop_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  dim_wr_t           dim_wr,
  input  start_t            start,
  output logic              idle,
  output alu_req_t          alu_req,
  input  logic [ACC_W-1:0]  alu_res,
  output logic              res_valid,
  input  logic              res_stall,
  output logic [SYM_W-1:0]  symbol,
  output logic [COST_W-1:0] min_cost,
  output logic [1:0]        status,
  output logic              end_of_run
);

  typedef enum logic [18:0] {
    S_IDLE = 19'h00001, S_LEN  = 19'h00002, S_PAIR = 19'h00004, S_RD1 = 19'h00008,
    S_RD2  = 19'h00010, S_RD3  = 19'h00020, S_MUL1 = 19'h00040, S_MUL2 = 19'h00080,
    S_SUM  = 19'h00100, S_CMP  = 19'h00200, S_WR   = 19'h00400, S_FIN = 19'h00800,
    S_COST = 19'h01000, S_POP  = 19'h02000, S_DEC  = 19'h04000, S_SPL = 19'h08000,
    S_P2   = 19'h10000, S_P3   = 19'h20000, S_OUT  = 19'h40000
  } state_t;

  state_t state;

  logic [DIM_BITS-1:0] dim_mem [MAX_DIMS];
  logic [COST_W-1:0]   cost_mem [TAB_DEPTH];
  logic [IDX_W-1:0]    split_mem [TAB_DEPTH];
  logic [ENTRY_W-1:0]  stack_mem [STACK_DEPTH];

  logic [IDX_W-1:0]    dim_raddr;
  logic [DIM_BITS-1:0] dim_rdata;
  logic [TADDR_W-1:0]  cost_raddr;
  logic [COST_W-1:0]   cost_rdata;
  logic [TADDR_W-1:0]  split_raddr;
  logic [IDX_W-1:0]    split_rdata;
  logic                stack_we;
  logic [SADDR_W-1:0]  stack_waddr;
  logic [ENTRY_W-1:0]  stack_wdata;
  logic [SADDR_W-1:0]  stack_raddr;
  logic [ENTRY_W-1:0]  stack_rdata;

  logic [CNT_W-1:0]    n;
  logic [CNT_W-1:0]    len;
  logic [IDX_W-1:0]    i;
  logic [IDX_W-1:0]    j;
  logic [IDX_W-1:0]    k;
  logic [COST_W-1:0]   c1;
  logic [COST_W-1:0]   c2;
  logic [DIM_BITS-1:0] d0;
  logic [DIM_BITS-1:0] d1;
  logic [DIM_BITS-1:0] d2;
  logic [COST_W-1:0]   best;
  logic [IDX_W-1:0]    bsplit;
  logic                have;
  logic [SP_W-1:0]     sp;
  logic [LET_W-1:0]    letter;
  logic [1:0]          st;

  logic [IDX_W-1:0]    e_i;
  logic [IDX_W-1:0]    e_j;
  logic [IDX_W-1:0]    n_top;
  logic                better;
  logic                room;

  assign e_i    = stack_rdata[ENTRY_W-1:IDX_W];
  assign e_j    = stack_rdata[IDX_W-1:0];
  assign n_top  = IDX_W'(n - CNT_W'(1));
  assign better = !have || (alu_res < ACC_W'(best));
  assign room   = ((SP_W+1)'(sp) + (SP_W+1)'(3)) <= (SP_W+1)'(STACK_DEPTH);

  assign idle       = (state == S_IDLE);
  assign res_valid  = (state == S_OUT);
  assign status     = st;

  // memory read addresses follow the state
  always_comb begin
    dim_raddr  = i - IDX_W'(1);
    cost_raddr = tab_addr(i, k);
    case (state)
      S_RD2: begin
        dim_raddr  = k;
        cost_raddr = tab_addr(IDX_W'(k + IDX_W'(1)), j);
      end
      S_RD3:   dim_raddr  = j;
      S_FIN:   cost_raddr = tab_addr(IDX_W'(1), n_top);
      default: ;
    endcase
  end

  assign split_raddr = tab_addr(e_i, e_j);
  assign stack_raddr = SADDR_W'(sp - SP_W'(1));

  always_comb begin
    stack_we    = 1'b0;
    stack_waddr = sp[SADDR_W-1:0];
    stack_wdata = '0;
    case (state)
      S_COST: begin
        stack_we    = 1'b1;
        stack_waddr = '0;
        stack_wdata = {IDX_W'(1), n_top};
      end
      S_SPL:   stack_we = room;
      S_P2: begin
        stack_we    = 1'b1;
        stack_wdata = {IDX_W'(k + IDX_W'(1)), j};
      end
      S_P3: begin
        stack_we    = 1'b1;
        stack_wdata = {i, k};
      end
      default: ;
    endcase
  end

  always_comb begin
    alu_req    = '0;
    alu_req.op = ALU_MUL;
    case (state)
      S_MUL1: begin
        alu_req.go = 1'b1;
        alu_req.a  = ACC_W'(d0);
        alu_req.b  = ACC_W'(d1);
      end
      S_MUL2: begin
        alu_req.go = 1'b1;
        alu_req.a  = alu_res;
        alu_req.b  = ACC_W'(d2);
      end
      S_SUM: begin
        alu_req.go = 1'b1;
        alu_req.op = ALU_SUM;
        alu_req.a  = ACC_W'(c1);
        alu_req.b  = ACC_W'(c2);
        alu_req.c  = alu_res;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (dim_wr.we) begin
      dim_mem[dim_wr.addr] <= dim_wr.data;
    end
    dim_rdata <= dim_mem[dim_raddr];
  end

  always_ff @(posedge clk) begin
    if (state == S_WR) begin
      cost_mem[tab_addr(i, j)]  <= best;
      split_mem[tab_addr(i, j)] <= bsplit;
    end
    cost_rdata  <= cost_mem[cost_raddr];
    split_rdata <= split_mem[split_raddr];
  end

  always_ff @(posedge clk) begin
    if (stack_we) begin
      stack_mem[stack_waddr] <= stack_wdata;
    end
    stack_rdata <= stack_mem[stack_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sp    <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start.go) begin
            n <= start.n;
            if (start.n < CNT_W'(2)) begin
              symbol     <= CH_NONE;
              min_cost   <= '0;
              st         <= ST_SHORT;
              end_of_run <= 1'b1;
              state      <= S_OUT;
            end else begin
              st    <= start.st;
              len   <= CNT_W'(2);
              state <= S_LEN;
            end
          end
        end
        S_LEN: begin
          if (len >= n) begin
            state <= S_FIN;
          end else begin
            i     <= IDX_W'(1);
            state <= S_PAIR;
          end
        end
        S_PAIR: begin
          if ((CNT_W+1)'(i) + (CNT_W+1)'(len) > (CNT_W+1)'(n)) begin
            len   <= len + CNT_W'(1);
            state <= S_LEN;
          end else begin
            j     <= IDX_W'(CNT_W'(i) + len - CNT_W'(1));
            k     <= i;
            have  <= 1'b0;
            state <= S_RD1;
          end
        end
        S_RD1:  state <= S_RD2;
        S_RD2: begin
          c1    <= (i == k) ? '0 : cost_rdata;
          d0    <= dim_rdata;
          state <= S_RD3;
        end
        S_RD3: begin
          c2    <= (IDX_W'(k + IDX_W'(1)) == j) ? '0 : cost_rdata;
          d1    <= dim_rdata;
          state <= S_MUL1;
        end
        S_MUL1: begin
          d2    <= dim_rdata;
          state <= S_MUL2;
        end
        S_MUL2: state <= S_SUM;
        S_SUM:  state <= S_CMP;
        S_CMP: begin
          if (better) begin
            best   <= alu_res[COST_W-1:0];
            bsplit <= k;
          end
          have <= 1'b1;
          if (IDX_W'(k + IDX_W'(1)) == j) begin
            state <= S_WR;
          end else begin
            k     <= k + IDX_W'(1);
            state <= S_RD1;
          end
        end
        S_WR: begin
          i     <= i + IDX_W'(1);
          state <= S_PAIR;
        end
        S_FIN:  state <= S_COST;
        S_COST: begin
          min_cost <= (n_top == IDX_W'(1)) ? '0 : cost_rdata;
          sp       <= SP_W'(1);
          letter   <= '0;
          state    <= S_POP;
        end
        S_POP: begin
          sp    <= sp - SP_W'(1);
          state <= S_DEC;
        end
        S_DEC: begin
          i          <= e_i;
          j          <= e_j;
          end_of_run <= (sp == '0);
          if (e_i == '0) begin
            symbol <= CH_CLOSE;
            state  <= S_OUT;
          end else if (e_i >= e_j) begin
            symbol <= CH_A + SYM_W'(letter);
            letter <= letter + LET_W'(1);
            state  <= S_OUT;
          end else begin
            symbol <= CH_OPEN;
            state  <= S_SPL;
          end
        end
        S_SPL: begin
          k <= split_rdata;
          if (room) begin
            sp    <= sp + SP_W'(1);
            state <= S_P2;
          end else begin
            state <= S_OUT;
          end
        end
        S_P2: begin
          sp    <= sp + SP_W'(1);
          state <= S_P3;
        end
        S_P3: begin
          sp         <= sp + SP_W'(1);
          end_of_run <= 1'b0;
          state      <= S_OUT;
        end
        S_OUT: begin
          if (!res_stall) begin
            state <= end_of_run ? S_IDLE : S_POP;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> design/matrix_chain_order_parenthesizer.sv
// channel   signals                                   direction  accepted when
// request   dim, last, req_valid, req_stall           in         req_valid && !req_stall
// result    symbol, min_cost, status, end_of_run,     out        res_valid && !res_stall
//           res_valid, res_stall
//
// loading takes one request per cycle while req_stall is low
// the request marked last starts the run; the table fill tries each split point
// in turn (about n^3/6 of them), bound by the single shared multiply/add unit
// each result symbol then comes from a stack walk plus its handshake
// req_stall stays high from the last request until the final result is taken
// synchronous active-high rst clears the load count, flags and sequencer state
module matrix_chain_order_parenthesizer import mcop_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic [DIM_BITS-1:0] dim,
  input  logic                last,
  input  logic                req_valid,
  output logic                req_stall,
  output logic [SYM_W-1:0]    symbol,
  output logic [COST_W-1:0]   min_cost,
  output logic [1:0]          status,
  output logic                end_of_run,
  output logic                res_valid,
  input  logic                res_stall
);

  // load side state
  logic [CNT_W-1:0] dim_count;
  logic             overflow_seen;
  logic             start_pend;
  logic [CNT_W-1:0] run_n;
  status_t          run_st;

  logic             req_take;
  logic             has_room;
  logic             seq_idle;
  dim_wr_t          dim_wr;
  start_t           start;
  alu_req_t         alu_req;
  logic [ACC_W-1:0] alu_res;

  // busy from the last request of a set until the run has drained
  assign req_stall = start_pend || !seq_idle;
  assign req_take  = req_valid && !req_stall;
  assign has_room  = dim_count < CNT_W'(MAX_DIMS);

  // dimensions go straight into the sequencer's store
  assign dim_wr.we   = req_take && has_room;
  assign dim_wr.addr = IDX_W'(dim_count);
  assign dim_wr.data = dim;

  assign start.go = start_pend;
  assign start.n  = run_n;
  assign start.st = run_st;

  always_ff @(posedge clk) begin
    if (rst) begin
      dim_count     <= '0;
      overflow_seen <= 1'b0;
      start_pend    <= 1'b0;
    end else begin
      start_pend <= 1'b0;
      if (req_take) begin
        if (last) begin
          // close the set; extra dimensions only raise the drop flag
          start_pend    <= 1'b1;
          run_n         <= has_room ? dim_count + CNT_W'(1) : dim_count;
          run_st        <= (overflow_seen || !has_room) ? ST_DROP : ST_OK;
          dim_count     <= '0;
          overflow_seen <= 1'b0;
        end else if (has_room) begin
          dim_count <= dim_count + CNT_W'(1);
        end else begin
          overflow_seen <= 1'b1;
        end
      end
    end
  end

  // shared multiply and saturating add
  mcop_alu u_alu (
    .clk (clk),
    .req (alu_req),
    .res (alu_res)
  );

  // table fill and parenthesis walk
  mcop_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .dim_wr     (dim_wr),
    .start      (start),
    .idle       (seq_idle),
    .alu_req    (alu_req),
    .alu_res    (alu_res),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .symbol     (symbol),
    .min_cost   (min_cost),
    .status     (status),
    .end_of_run (end_of_run)
  );

endmodule

>>> design/mcop_checker.sv
`include "matrix_chain_order_parenthesizer_assert.svh"

module mcop_checker import mcop_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic [DIM_BITS-1:0] dim,
  input logic                last,
  input logic                req_valid,
  input logic                req_stall,
  input logic [SYM_W-1:0]    symbol,
  input logic [COST_W-1:0]   min_cost,
  input logic [1:0]          status,
  input logic                end_of_run,
  input logic                res_valid,
  input logic                res_stall
);

  logic short_ok;
  logic out_wait;

  assign short_ok = end_of_run && (symbol == CH_NONE) && (min_cost == '0);
  assign out_wait = !rst && res_valid && res_stall;

  // no new request is taken while a result is on offer
  `MCOP_ASSERT(a_busy_out, res_valid |-> req_stall, "request taken during result output")

  // the last request of a set closes the input
  `MCOP_ASSERT(a_last_stall, (req_valid && !req_stall && last) |=> req_stall, "open after last")

  // a short chain gives one bare error result
  `MCOP_ASSERT(a_short, (res_valid && status == ST_SHORT) |-> short_ok, "bad short-chain result")

  // a stalled result holds
  `MCOP_ASSERT_ALWAYS(a_hold, out_wait |=> (res_valid && $stable(symbol)), "stalled result changed")

endmodule

bind matrix_chain_order_parenthesizer mcop_checker u_mcop_checker (.*);
